// ----- hw/rtl/itr_pkg.sv -----
// Shared types, constants and greedy table lookups for the integer to Roman
// numeral converter. No dependencies; every other RTL file imports this package.
package itr_pkg;

    localparam int NUM_W       = 12;
    localparam int SYM_W       = 8;
    localparam int ENTRIES     = 13;
    localparam int ENT_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [NUM_W-1:0] MAX_VALUE = NUM_W'(3999);

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             range_error;
    } t_item;

    function automatic logic [NUM_W-1:0] value_of(input logic [ENT_W-1:0] e);
        logic [NUM_W-1:0] v;
        case (e)
            4'd0:    v = NUM_W'(1000);
            4'd1:    v = NUM_W'(900);
            4'd2:    v = NUM_W'(500);
            4'd3:    v = NUM_W'(400);
            4'd4:    v = NUM_W'(100);
            4'd5:    v = NUM_W'(90);
            4'd6:    v = NUM_W'(50);
            4'd7:    v = NUM_W'(40);
            4'd8:    v = NUM_W'(10);
            4'd9:    v = NUM_W'(9);
            4'd10:   v = NUM_W'(5);
            4'd11:   v = NUM_W'(4);
            default: v = NUM_W'(1);
        endcase
        return v;
    endfunction

    function automatic logic [SYM_W-1:0] first_of(input logic [ENT_W-1:0] e);
        logic [SYM_W-1:0] s;
        case (e)
            4'd0:    s = SYM_M;
            4'd1:    s = SYM_C;
            4'd2:    s = SYM_D;
            4'd3:    s = SYM_C;
            4'd4:    s = SYM_C;
            4'd5:    s = SYM_X;
            4'd6:    s = SYM_L;
            4'd7:    s = SYM_X;
            4'd8:    s = SYM_X;
            4'd9:    s = SYM_I;
            4'd10:   s = SYM_V;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] second_of(input logic [ENT_W-1:0] e);
        logic [SYM_W-1:0] s;
        case (e)
            4'd1:    s = SYM_M;
            4'd3:    s = SYM_D;
            4'd5:    s = SYM_C;
            4'd7:    s = SYM_L;
            4'd9:    s = SYM_X;
            4'd11:   s = SYM_V;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/integer_to_roman_unit.sv -----
// Top level of the integer to Roman numeral converter.
// Depends on itr_pkg, itr_front, itr_queue and itr_back.
//
//  Channel  Signals                                        Direction
//  input    i_valid, o_ready, i_number[11:0]               one number per transfer
//  output   o_valid, i_ready, o_symbol[7:0], o_last,       one symbol per transfer
//           o_range_error
//
// The sequencer first loads an item from the queue, then emits one symbol per
// cycle while the output is not stalled; an out-of-range value gives a single
// null symbol instead.
// The queue holds QUEUE_DEPTH items, so numbers keep being accepted while a
// numeral is still being emitted. Output stalls hold the symbol in place.
// Reset is synchronous and empties the input register, queue and sequencer.
module integer_to_roman_unit #(
    parameter int QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [itr_pkg::NUM_W-1:0] i_number,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [itr_pkg::SYM_W-1:0] o_symbol,
    output logic                      o_last,
    output logic                      o_range_error
);
    import itr_pkg::*;

    t_item front_item, queue_item;
    logic  front_valid, queue_in_ready, queue_valid, back_ready;

    itr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_number     (i_number),
        .o_item_valid (front_valid),
        .i_item_ready (queue_in_ready),
        .o_item       (front_item)
    );

    itr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_in_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_item  (queue_item)
    );

    itr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (queue_valid),
        .o_item_ready  (back_ready),
        .i_item        (queue_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

endmodule

// ----- hw/rtl/itr_front.sv -----
// Input stage of the converter: registers each input transfer and flags values
// outside 1 to 3999. Depends on itr_pkg.
module itr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [itr_pkg::NUM_W-1:0] i_number,
    output logic                     o_item_valid,
    input  logic                     i_item_ready,
    output itr_pkg::t_item           o_item
);
    import itr_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_item_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.number      <= i_number;
            r_item.range_error <= (i_number == '0) || (i_number > MAX_VALUE);
        end
    end

endmodule

// ----- hw/rtl/itr_queue.sv -----
// Small FIFO of classified items between the input stage and the symbol
// sequencer. Depends on itr_pkg.
module itr_queue #(
    parameter int DEPTH = itr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  itr_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output itr_pkg::t_item o_item
);
    import itr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/itr_back.sv -----
// Symbol sequencer: walks the greedy table for one item and emits one symbol per
// cycle into an output register while the output is not stalled. Depends on itr_pkg.
module itr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    output logic                      o_item_ready,
    input  itr_pkg::t_item            i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [itr_pkg::SYM_W-1:0] o_symbol,
    output logic                      o_last,
    output logic                      o_range_error
);
    import itr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_SECOND = 4'b0100,
        ST_ERROR  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [NUM_W-1:0] r_rest, n_rest;
    logic [ENT_W-1:0] r_entry, n_entry;
    logic             r_out_valid, n_out_valid;
    logic [SYM_W-1:0] r_symbol, n_symbol;
    logic             r_last, n_last;
    logic             r_err, n_err;

    logic             emit;
    logic [ENT_W-1:0] found;
    logic [NUM_W-1:0] rest_after;

    assign o_item_ready  = (r_state == ST_IDLE);
    assign emit          = (r_state != ST_IDLE) && (!r_out_valid || i_ready);
    assign o_valid       = r_out_valid;
    assign o_symbol      = r_symbol;
    assign o_last        = r_last;
    assign o_range_error = r_err;

    // The first table entry at or after the current one that still fits.
    always_comb begin
        found = r_entry;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (ENT_W'(k) >= r_entry && r_rest >= value_of(ENT_W'(k))) begin
                found = ENT_W'(k);
            end
        end
        rest_after = r_rest - value_of(found);
    end

    always_comb begin
        n_state     = r_state;
        n_rest      = r_rest;
        n_entry     = r_entry;
        n_out_valid = r_out_valid;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_err       = r_err;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_rest  = i_item.number;
                    n_entry = '0;
                    n_state = i_item.range_error ? ST_ERROR : ST_WALK;
                end
            end
            ST_WALK: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_symbol    = first_of(found);
                    n_err       = 1'b0;
                    n_rest      = rest_after;
                    n_entry     = found;
                    if (second_of(found) != SYM_NONE) begin
                        n_last  = 1'b0;
                        n_state = ST_SECOND;
                    end else begin
                        n_last  = (rest_after == '0);
                        n_state = (rest_after == '0) ? ST_IDLE : ST_WALK;
                    end
                end
            end
            ST_SECOND: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_symbol    = second_of(r_entry);
                    n_err       = 1'b0;
                    n_last      = (r_rest == '0);
                    n_state     = (r_rest == '0) ? ST_IDLE : ST_WALK;
                end
            end
            ST_ERROR: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_symbol    = SYM_NONE;
                    n_err       = 1'b1;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest   <= n_rest;
        r_entry  <= n_entry;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_err    <= n_err;
    end

endmodule

// ----- hw/rtl/itr_checker.sv -----
// Port-level assertions for integer_to_roman_unit and the bind that attaches
// them. Depends on itr_pkg.
module itr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [itr_pkg::SYM_W-1:0] o_symbol,
    input logic                      o_last,
    input logic                      o_range_error
);
    import itr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_symbol) && $stable(o_last)
            && $stable(o_range_error))
        else $error("Stalled output transfer changed.");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_last && (o_symbol == SYM_NONE))
        else $error("Range error result is not a single null symbol.");

    a_symbol_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |-> (o_symbol == SYM_I) || (o_symbol == SYM_V)
            || (o_symbol == SYM_X) || (o_symbol == SYM_L) || (o_symbol == SYM_C)
            || (o_symbol == SYM_D) || (o_symbol == SYM_M))
        else $error("Output symbol is not a Roman numeral letter.");

    a_numeral_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("Gap inside a numeral.");

endmodule

bind integer_to_roman_unit itr_checker u_itr_checker (.*);

// ----- test/integer_to_roman_unit_test.sv -----
// Testbench for integer_to_roman_unit: drives numbers with random gaps and checks every
// emitted symbol against a greedy Roman numeral predictor kept in a scoreboard class.
// Depends on itr_pkg and the integer_to_roman_unit RTL.
import itr_pkg::*;

class roman_scoreboard;
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             range_error;
    } roman_symbol_t;

    roman_symbol_t expected_symbols[$];
    int unsigned   mismatches;

    int unsigned      step_value[ENTRIES] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                              10, 9, 5, 4, 1};
    logic [SYM_W-1:0] lead_symbol[ENTRIES] = '{SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X,
                                               SYM_L, SYM_X, SYM_X, SYM_I, SYM_V, SYM_I,
                                               SYM_I};
    logic [SYM_W-1:0] tail_symbol[ENTRIES] = '{SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE,
                                               SYM_C, SYM_NONE, SYM_L, SYM_NONE, SYM_X,
                                               SYM_NONE, SYM_V, SYM_NONE};

    function new();
        mismatches = 0;
    endfunction

    function void note_number(logic [NUM_W-1:0] number);
        int unsigned   rest;
        roman_symbol_t numeral[$];
        rest = number;
        if (number == 0 || number > MAX_VALUE) begin
            numeral.push_back('{SYM_NONE, 1'b1, 1'b1});
        end else begin
            for (int e = 0; e < ENTRIES; e++) begin
                while (rest >= step_value[e]) begin
                    rest -= step_value[e];
                    numeral.push_back('{lead_symbol[e], 1'b0, 1'b0});
                    if (tail_symbol[e] != SYM_NONE) begin
                        numeral.push_back('{tail_symbol[e], 1'b0, 1'b0});
                    end
                end
            end
            numeral[numeral.size()-1].last = 1'b1;
        end
        foreach (numeral[k]) expected_symbols.push_back(numeral[k]);
    endfunction

    function void check_symbol(logic [SYM_W-1:0] symbol, logic last, logic range_error);
        roman_symbol_t want;
        if (expected_symbols.size() == 0) begin
            $error("unexpected symbol transfer: symbol %h last %b range_error %b",
                   symbol, last, range_error);
            mismatches++;
        end else begin
            want = expected_symbols.pop_front();
            if (symbol !== want.symbol) begin
                $error("symbol: expected %h, actual %h", want.symbol, symbol);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, last);
                mismatches++;
            end
            if (range_error !== want.range_error) begin
                $error("range_error: expected %b, actual %b", want.range_error, range_error);
                mismatches++;
            end
        end
    endfunction

    function int unsigned pending();
        return expected_symbols.size();
    endfunction
endclass

module integer_to_roman_unit_test;
    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [NUM_W-1:0] i_number;
    logic             o_valid;
    logic             i_ready;
    logic [SYM_W-1:0] o_symbol;
    logic             o_last;
    logic             o_range_error;

    roman_scoreboard sb;

    integer_to_roman_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return ($urandom_range(0, 1) == 0) ? NUM_W'(0)
                                                       : NUM_W'($urandom_range(4000, 4095));
        if (r < 25) return NUM_W'($urandom_range(1, 50));
        return NUM_W'($urandom_range(1, 3999));
    endfunction

    task automatic send_number(input logic [NUM_W-1:0] number);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_number = number;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_number(i_number);
            if (o_valid && i_ready) sb.check_symbol(o_symbol, o_last, o_range_error);
        end
    end

    initial begin
        int run;
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            run = $urandom_range(1, 20);
            i_ready = 1'b1;
            repeat (run) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    initial begin
        int unsigned directed[];
        directed = '{1, 3999, 0, 4000, 4095, 3888, 4, 9, 40, 90, 400,
                     900, 1000, 5, 10, 50, 100, 500, 2047, 2048, 1444,
                     3, 1994, 2730, 1365};
        sb       = new();
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_number = '0;
        i_ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[k]) send_number(NUM_W'(directed[k]));
        repeat (330) send_number(pick_number());
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
